### hw/rtl/rtt_pkg.sv
// shared types and constants of the request timeout retry tracker
// no dependencies; imported by every module of the tracker
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

   localparam int unsigned ID_W     = 32;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned TMO_W    = 31;
   localparam int unsigned RESEND_W = 8;
   localparam int unsigned KIND_W   = 4;
   localparam int unsigned ACT_W    = 2;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ADDR_W   = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_ISSUE   = 2'd0,
      ACT_REPLY   = 2'd1,
      ACT_REFRESH = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ISSUED     = 4'd0,
      KIND_FULL       = 4'd1,
      KIND_MATCHED    = 4'd2,
      KIND_UNKNOWN    = 4'd3,
      KIND_RESEND     = 4'd4,
      KIND_TIMEOUT    = 4'd5,
      KIND_INTERVAL   = 4'd6,
      KIND_CLEARED    = 4'd7,
      KIND_CLEAR_DONE = 4'd8
   } kind_type;

   typedef enum logic {
      REG_TIMEOUT     = 1'b0,
      REG_MAX_RESENDS = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_REPLY,
      ST_REFRESH,
      ST_CLEAR
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_UPDATE,
      CELL_DELETE,
      CELL_POP
   } cell_mode_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   deadline;
      logic [RESEND_W-1:0] resends;
   } entry_type;

   typedef struct packed {
      cell_mode_type   mode;
      logic            keep;
      logic [ID_W-1:0] key;
      entry_type       fill;
   } cell_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/rtt_cell.sv
// one cell of the sorted request chain: holds one entry, shifts to its neighbors
// depends on rtt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtt_cell (
   input  logic                 clock,
   input  rtt_pkg::cell_ctl_type ctl,
   input  logic                 cell_valid,
   input  logic                 cell_tail,
   input  rtt_pkg::entry_type   left_ent,
   input  logic                 left_flag,
   input  rtt_pkg::entry_type   right_ent,
   output rtt_pkg::entry_type   ent,
   output logic                 flag_o,
   output logic                 match_o
);
   import rtt_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;
   logic      gt;

   assign match_o = cell_valid && (ent_ff.id == ctl.key);
   assign gt      = ent_ff.id > ctl.key;
   assign ent     = ent_ff;

   always_comb begin
      unique case (ctl.mode)
         CELL_INSERT: flag_o = !cell_valid || gt;
         CELL_DELETE: flag_o = left_flag || match_o;
         default:     flag_o = 1'b0;
      endcase
   end

   always_comb begin
      ent_in = ent_ff;
      unique case (ctl.mode)
         CELL_INSERT: begin
            if (left_flag) begin
               ent_in = left_ent;
            end else if (flag_o) begin
               ent_in = ctl.fill;
            end
         end
         CELL_UPDATE: begin
            if (match_o) begin
               ent_in = ctl.fill;
            end
         end
         CELL_DELETE: begin
            if (flag_o) begin
               ent_in = right_ent;
            end
         end
         CELL_POP: begin
            if (cell_tail && ctl.keep) begin
               ent_in = ctl.fill;
            end else begin
               ent_in = right_ent;
            end
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

`default_nettype wire

### hw/rtl/rtt_chain.sv
// chain of entry cells kept packed and sorted by ascending id
// depends on rtt_pkg and rtt_cell
`timescale 1ns / 1ps
`default_nettype none

module rtt_chain #(
   parameter int unsigned  TABLE_DEPTH = 16,
   localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                  clock,
   input  rtt_pkg::cell_ctl_type ctl,
   input  logic [CNT_W-1:0]      count,
   output rtt_pkg::entry_type    head,
   output logic                  any_match
);
   import rtt_pkg::*;

   entry_type              ents  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] flags;
   logic [TABLE_DEPTH-1:0] hits;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type left_ent;
      entry_type right_ent;
      logic      left_flag;
      logic      cell_valid;
      logic      cell_tail;

      assign cell_valid = CNT_W'(i) < count;
      assign cell_tail  = CNT_W'(i + 1) == count;

      if (i == 0) begin : g_first
         assign left_ent  = '0;
         assign left_flag = 1'b0;
      end else begin : g_mid
         assign left_ent  = ents[i-1];
         assign left_flag = flags[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_ent = '0;
      end else begin : g_inner
         assign right_ent = ents[i+1];
      end

      rtt_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_valid (cell_valid),
         .cell_tail  (cell_tail),
         .left_ent   (left_ent),
         .left_flag  (left_flag),
         .right_ent  (right_ent),
         .ent        (ents[i]),
         .flag_o     (flags[i]),
         .match_o    (hits[i])
      );
   end

   assign head      = ents[0];
   assign any_match = |hits;

endmodule

`default_nettype wire

### hw/rtl/request_timeout_retry_tracker_unit.sv
// Outstanding request table with timeouts and resends.
// Input channel (req_*): one word per action: issue, reply, refresh, clear,
// with a reply id and the current millisecond time. Result channel (rsp_*):
// one or more words per action; the final one carries rsp_last.
// Registers on an APB-style port: timeout_ms at 0x0, max_resends at 0x4.
// Entries sit in a chain of cells packed at the head and sorted by id.
// Issue and reply pass the ISSUE or REPLY state, then the output register.
// Refresh and clear pop one entry off the head of the chain per cycle while
// the result channel does not stall, one per entry, at most TABLE_DEPTH.
// The next word is accepted in the cycle after the final result is loaded
// into the output register; one action is worked on at a time.
// A stall on the result channel holds the output register and freezes the
// sequencer until the word is taken; an idle sequencer still accepts a word.
// Reset empties the table, zeroes the last issued id, sets timeout_ms to 1000
// and max_resends to 0.
// depends on rtt_pkg and rtt_chain
`timescale 1ns / 1ps
`default_nettype none

module request_timeout_retry_tracker_unit #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [rtt_pkg::ACT_W-1:0]   req_action,
   input  logic [rtt_pkg::ID_W-1:0]    req_reply_id,
   input  logic [rtt_pkg::TIME_W-1:0]  req_now_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rtt_pkg::KIND_W-1:0]  rsp_kind,
   output logic [rtt_pkg::ID_W-1:0]    rsp_request_id,
   output logic [rtt_pkg::TMO_W-1:0]   rsp_interval_ms,
   output logic                        rsp_last,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rtt_pkg::ADDR_W-1:0]  paddr,
   input  logic [rtt_pkg::DATA_W-1:0]  pwdata,
   output logic [rtt_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import rtt_pkg::*;

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [ID_W-1:0]     key_ff, key_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [TMO_W-1:0]    interval_ff, interval_in;
   logic [ID_W-1:0]     last_id_ff, last_id_in;
   logic [TMO_W-1:0]    timeout_ff;
   logic [RESEND_W-1:0] max_resends_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [TMO_W-1:0]    rsp_interval_ff;
   logic                rsp_last_ff;

   logic                req_accept;
   logic                can_emit;
   logic                emit;
   kind_type            emit_kind;
   logic [ID_W-1:0]     emit_id;
   logic [TMO_W-1:0]    emit_interval;
   logic                emit_last;

   cell_ctl_type        ctl;
   entry_type           head;
   logic                any_match;
   logic [TIME_W-1:0]   new_deadline;
   logic [TIME_W-1:0]   head_left;
   logic                head_alive;
   logic                csr_write;
   reg_index_type       csr_index;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[2]);

   always_comb begin
      unique case (csr_index)
         REG_TIMEOUT:     prdata = {{(DATA_W - TMO_W){1'b0}}, timeout_ff};
         REG_MAX_RESENDS: prdata = {{(DATA_W - RESEND_W){1'b0}}, max_resends_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TMO_W'(1000);
         max_resends_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TIMEOUT:     timeout_ff     <= pwdata[TMO_W-1:0];
            REG_MAX_RESENDS: max_resends_ff <= pwdata[RESEND_W-1:0];
            default:         timeout_ff     <= timeout_ff;
         endcase
      end
   end

   // sequencer
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign can_emit     = !rsp_valid_ff || !rsp_stall;
   assign new_deadline = now_ff + {{(TIME_W - TMO_W){1'b0}}, timeout_ff};
   assign head_left    = head.deadline - now_ff;
   assign head_alive   = !head_left[TIME_W-1] && (head_left != '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      interval_in   = interval_ff;
      last_id_in    = last_id_ff;
      emit          = 1'b0;
      emit_kind     = KIND_ISSUED;
      emit_id       = '0;
      emit_interval = '0;
      emit_last     = 1'b0;
      ctl.mode      = CELL_HOLD;
      ctl.keep      = 1'b0;
      ctl.key       = key_ff;
      ctl.fill      = '{id: key_ff, deadline: new_deadline, resends: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               steps_in    = count_ff;
               now_in      = req_now_ms;
               interval_in = timeout_ff;
               unique case (action_type'(req_action))
                  ACT_ISSUE: begin
                     state_in = ST_ISSUE;
                     key_in   = last_id_ff + ID_W'(1);
                  end
                  ACT_REPLY: begin
                     state_in = ST_REPLY;
                     key_in   = req_reply_id;
                  end
                  ACT_REFRESH: state_in = ST_REFRESH;
                  ACT_CLEAR:   state_in = ST_CLEAR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ISSUE: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
               if (any_match) begin
                  ctl.mode   = CELL_UPDATE;
                  emit_id    = key_ff;
                  last_id_in = key_ff;
               end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  emit_kind = KIND_FULL;
               end else begin
                  ctl.mode   = CELL_INSERT;
                  count_in   = count_ff + CNT_W'(1);
                  emit_id    = key_ff;
                  last_id_in = key_ff;
               end
            end
         end
         ST_REPLY: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               emit_id   = key_ff;
               state_in  = ST_IDLE;
               if (any_match) begin
                  ctl.mode  = CELL_DELETE;
                  count_in  = count_ff - CNT_W'(1);
                  emit_kind = KIND_MATCHED;
               end else begin
                  emit_kind = KIND_UNKNOWN;
               end
            end
         end
         ST_REFRESH: begin
            if (can_emit) begin
               if (steps_ff != '0) begin
                  steps_in = steps_ff - CNT_W'(1);
                  ctl.mode = CELL_POP;
                  if (head_alive) begin
                     ctl.keep = 1'b1;
                     ctl.fill = head;
                     if (head_left[TMO_W-1:0] < interval_ff) begin
                        interval_in = head_left[TMO_W-1:0];
                     end
                  end else if (head.resends < max_resends_ff) begin
                     ctl.keep  = 1'b1;
                     ctl.fill  = '{id: head.id, deadline: new_deadline,
                                   resends: head.resends + RESEND_W'(1)};
                     emit      = 1'b1;
                     emit_kind = KIND_RESEND;
                     emit_id   = head.id;
                  end else begin
                     count_in  = count_ff - CNT_W'(1);
                     emit      = 1'b1;
                     emit_kind = KIND_TIMEOUT;
                     emit_id   = head.id;
                  end
               end else begin
                  emit          = 1'b1;
                  emit_kind     = KIND_INTERVAL;
                  emit_interval = interval_ff;
                  emit_last     = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_CLEAR: begin
            if (can_emit) begin
               emit = 1'b1;
               if (steps_ff != '0) begin
                  steps_in  = steps_ff - CNT_W'(1);
                  count_in  = count_ff - CNT_W'(1);
                  ctl.mode  = CELL_POP;
                  emit_kind = KIND_CLEARED;
                  emit_id   = head.id;
               end else begin
                  emit_kind = KIND_CLEAR_DONE;
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         steps_ff   <= '0;
         last_id_ff <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         steps_ff   <= steps_in;
         last_id_ff <= last_id_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      now_ff      <= now_in;
      interval_ff <= interval_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff     <= emit_kind;
         rsp_id_ff       <= emit_id;
         rsp_interval_ff <= emit_interval;
         rsp_last_ff     <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_request_id  = rsp_id_ff;
   assign rsp_interval_ms = rsp_interval_ff;
   assign rsp_last        = rsp_last_ff;

   rtt_chain #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .count     (count_ff),
      .head      (head),
      .any_match (any_match)
   );

endmodule

`default_nettype wire

### hw/rtl/rtt_checker.sv
// port-level checks of the request timeout retry tracker, bound to its top level
// depends on rtt_pkg and request_timeout_retry_tracker_unit
`timescale 1ns / 1ps
`default_nettype none

module rtt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [rtt_pkg::KIND_W-1:0] rsp_kind,
   input logic [rtt_pkg::ID_W-1:0]   rsp_request_id,
   input logic [rtt_pkg::TMO_W-1:0]  rsp_interval_ms,
   input logic                       rsp_last
);
   import rtt_pkg::*;

   // one action at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("word accepted while an action is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_request_id) && $stable(rsp_last))
      else $error("stalled result word changed");

   a_interval_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_INTERVAL |-> rsp_interval_ms == '0)
      else $error("interval on a non-interval result");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == !(rsp_kind == KIND_RESEND || rsp_kind == KIND_TIMEOUT
         || rsp_kind == KIND_CLEARED))
      else $error("last flag disagrees with result kind");

   a_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_FULL || rsp_kind == KIND_CLEAR_DONE)
         |-> rsp_request_id == '0)
      else $error("id on a result that carries none");

endmodule

bind request_timeout_retry_tracker_unit rtt_checker u_rtt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_request_id  (rsp_request_id),
   .rsp_interval_ms (rsp_interval_ms),
   .rsp_last        (rsp_last)
);

`default_nettype wire

### tb/request_timeout_retry_tracker_unit_tb.sv
// testbench for request_timeout_retry_tracker_unit: directed and random words with a
// table predictor, random stalls on both channels and register writes between phases
// depends on rtt_pkg and the tracker rtl
`timescale 1ns / 1ps

module request_timeout_retry_tracker_unit_tb;
   import rtt_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      action_type        action;
      logic [ID_W-1:0]   reply_id;
      logic [TIME_W-1:0] now_ms;
   } tracker_word_t;

   typedef struct packed {
      kind_type         kind;
      logic [ID_W-1:0]  request_id;
      logic [TMO_W-1:0] interval_ms;
      logic             last;
   } result_word_t;

   logic clock;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   action_type        req_action = ACT_ISSUE;
   logic [ID_W-1:0]   req_reply_id = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [ID_W-1:0]   rsp_request_id;
   logic [TMO_W-1:0]  rsp_interval_ms;
   logic              rsp_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   request_timeout_retry_tracker_unit #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_reply_id(req_reply_id),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_request_id(rsp_request_id),
      .rsp_interval_ms(rsp_interval_ms),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // predicted table state and registers
   bit                  tbl_valid [TABLE_DEPTH];
   logic [ID_W-1:0]     tbl_id [TABLE_DEPTH];
   logic [TIME_W-1:0]   tbl_deadline [TABLE_DEPTH];
   logic [RESEND_W-1:0] tbl_resends [TABLE_DEPTH];
   logic [ID_W-1:0]     tbl_last_id = '0;
   logic [TMO_W-1:0]    cfg_timeout = 31'd1000;
   logic [RESEND_W-1:0] cfg_max_resends = '0;

   tracker_word_t pending_words[$];
   result_word_t  expected_results[$];
   tracker_word_t offered;
   int            gap_left = 0;
   int            stall_left = 0;
   int            errors = 0;
   bit            idle_on = 1'b1;
   int            holds_asked = 0;
   int            holds_served = 0;
   int            long_hold_left = 0;
   logic [ID_W-1:0]   issued_guess = '0;
   logic [TIME_W-1:0] gen_now = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void expect_word(kind_type kind, logic [ID_W-1:0] id,
                                       logic [TMO_W-1:0] interval, logic last);
      result_word_t w;
      w = '{kind, id, interval, last};
      expected_results.insert(expected_results.size(), w);
   endfunction

   function automatic void track_request_action(tracker_word_t w);
      logic [ID_W-1:0]   next_id;
      logic [TIME_W-1:0] diff;
      int                slot;
      int                pick;
      int                left;
      longint            interval;
      bit                seen [TABLE_DEPTH];
      slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) seen[i] = 1'b0;
      case (w.action)
         ACT_ISSUE: begin
            next_id = tbl_last_id + ID_W'(1);
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (slot < 0 && tbl_valid[i] && tbl_id[i] == next_id) slot = i;
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (slot < 0 && !tbl_valid[i]) slot = i;
            if (slot < 0) begin
               expect_word(KIND_FULL, '0, '0, 1'b1);
            end else begin
               tbl_last_id = next_id;
               tbl_valid[slot] = 1'b1;
               tbl_id[slot] = next_id;
               tbl_deadline[slot] = w.now_ms + TIME_W'(cfg_timeout);
               tbl_resends[slot] = '0;
               expect_word(KIND_ISSUED, next_id, '0, 1'b1);
            end
         end
         ACT_REPLY: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (slot < 0 && tbl_valid[i] && tbl_id[i] == w.reply_id) slot = i;
            if (slot < 0) begin
               expect_word(KIND_UNKNOWN, w.reply_id, '0, 1'b1);
            end else begin
               tbl_valid[slot] = 1'b0;
               expect_word(KIND_MATCHED, w.reply_id, '0, 1'b1);
            end
         end
         default: begin
            interval = longint'(cfg_timeout);
            // visit live entries in ascending id order
            for (int m = 0; m < TABLE_DEPTH; m++) begin
               pick = -1;
               for (int i = 0; i < TABLE_DEPTH; i++)
                  if (tbl_valid[i] && !seen[i] && (pick < 0 || tbl_id[i] < tbl_id[pick]))
                     pick = i;
               if (pick >= 0) begin
                  seen[pick] = 1'b1;
                  if (w.action == ACT_CLEAR) begin
                     tbl_valid[pick] = 1'b0;
                     expect_word(KIND_CLEARED, tbl_id[pick], '0, 1'b0);
                  end else begin
                     diff = tbl_deadline[pick] - w.now_ms;
                     left = diff;
                     if (left > 0) begin
                        if (left < interval) interval = left;
                     end else if (tbl_resends[pick] < cfg_max_resends) begin
                        tbl_resends[pick] = tbl_resends[pick] + RESEND_W'(1);
                        tbl_deadline[pick] = w.now_ms + TIME_W'(cfg_timeout);
                        expect_word(KIND_RESEND, tbl_id[pick], '0, 1'b0);
                     end else begin
                        tbl_valid[pick] = 1'b0;
                        expect_word(KIND_TIMEOUT, tbl_id[pick], '0, 1'b0);
                     end
                  end
               end
            end
            if (w.action == ACT_CLEAR) expect_word(KIND_CLEAR_DONE, '0, '0, 1'b1);
            else expect_word(KIND_INTERVAL, '0, TMO_W'(interval), 1'b1);
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      bit send_now;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         send_now = !req_valid;
         if (req_valid && !req_stall) begin
            track_request_action(offered);
            send_now = 1'b1;
            gap_left = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (send_now) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               offered = pending_words.pop_front();
               req_valid <= 1'b1;
               req_action <= offered.action;
               req_reply_id <= offered.reply_id;
               req_now_ms <= offered.now_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
         holds_served <= 0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         long_hold_left <= HOLD_CYCLES;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_word_t exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result word: kind %0d id %h interval %0d last %0b",
                           rsp_kind, rsp_request_id, rsp_interval_ms, rsp_last);
            end else begin
               exp_w = expected_results.pop_front();
               if (rsp_kind !== exp_w.kind || rsp_request_id !== exp_w.request_id ||
                   rsp_interval_ms !== exp_w.interval_ms || rsp_last !== exp_w.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected kind %0d id %h interval %0d last %0b, %s",
                              exp_w.kind, exp_w.request_id, exp_w.interval_ms, exp_w.last,
                              $sformatf("got kind %0d id %h interval %0d last %0b",
                                        rsp_kind, rsp_request_id, rsp_interval_ms,
                                        rsp_last));
               end
            end
            stall_left = idle_on ? $urandom_range(0, 3) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0) || (long_hold_left != 0);
      end
   end

   task automatic queue_word(action_type action, logic [ID_W-1:0] reply_id,
                             logic [TIME_W-1:0] now_ms);
      tracker_word_t w;
      w = '{action, reply_id, now_ms};
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic queue_random(int count, int unsigned span);
      int unsigned pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            queue_word(action_type'($urandom_range(0, 3)), $urandom, $urandom);
         end else if (pick < 40) begin
            issued_guess++;
            queue_word(ACT_ISSUE, $urandom, gen_now);
         end else if (pick < 65) begin
            queue_word(ACT_REPLY, issued_guess - $urandom_range(0, 20), gen_now);
         end else if (pick < 95) begin
            queue_word(ACT_REFRESH, $urandom, gen_now);
         end else begin
            queue_word(ACT_CLEAR, $urandom, gen_now);
         end
         gen_now += $urandom_range(0, span);
      end
   endtask

   task automatic drain_results();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic write_reg(reg_index_type idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_TIMEOUT) cfg_timeout = value[TMO_W-1:0];
      else cfg_max_resends = value[RESEND_W-1:0];
   endtask

   task automatic start_phase(logic [DATA_W-1:0] timeout, logic [DATA_W-1:0] resends,
                              bit idling);
      write_reg(REG_TIMEOUT, timeout);
      write_reg(REG_MAX_RESENDS, resends);
      @(negedge clock);
      idle_on = idling;
      issued_guess = tbl_last_id;
   endtask

   initial begin
      logic [TIME_W-1:0] base;
      int unsigned       tmo;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_id[i] = '0;
         tbl_deadline[i] = '0;
         tbl_resends[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values: empty table cases, unknown and matched reply
      @(negedge clock);
      queue_word(ACT_REFRESH, $urandom, 32'd0);
      queue_word(ACT_CLEAR, $urandom, 32'd5);
      queue_word(ACT_REPLY, 32'hFFFF_FFFF, 32'd7);
      queue_word(ACT_ISSUE, $urandom, 32'd100);
      queue_word(ACT_REPLY, 32'd1, 32'd150);
      drain_results();

      // fill the table across the time wrap, then resend, time out and clear
      start_phase(32'd10, 32'd1, 1'b1);
      base = 32'hFFFF_FFF8;
      for (int i = 0; i <= TABLE_DEPTH; i++) queue_word(ACT_ISSUE, $urandom, base + i);
      queue_word(ACT_REFRESH, $urandom, base + 17);
      queue_word(ACT_REFRESH, $urandom, base + 27);
      queue_word(ACT_CLEAR, $urandom, base + 30);
      drain_results();

      start_phase(32'd0, 32'h0000_00FF, 1'b1);
      gen_now = $urandom;
      queue_random(25, 50);
      drain_results();

      start_phase(32'hFFFF_FFFF, 32'd0, 1'b1);
      queue_random(25, 32'h4000_0000);
      drain_results();

      // receiver holds off while requests keep coming
      start_phase(32'd1000, 32'd2, 1'b1);
      holds_asked++;
      queue_random(50, 400);
      drain_results();

      tmo = $urandom_range(1, 5000);
      start_phase(tmo, $urandom_range(0, 3), 1'b0);
      queue_random(25, tmo / 2 + 1);
      drain_results();

      repeat (40) @(negedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("request_timeout_retry_tracker_unit verification clean");
      else
         $display("request_timeout_retry_tracker_unit verification failed");
      $finish;
   end

   initial begin
      #400000;
      $display("request_timeout_retry_tracker_unit verification failed");
      $finish;
   end

endmodule
